// ----- rtl/ring_index_queue_assert.svh -----
// assertion macros for the queue rtl, used by riq_ctrl
`ifndef RING_INDEX_QUEUE_ASSERT_SVH
`define RING_INDEX_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RIQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue assertion failed");

// next-cycle implication
`define RIQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue assertion failed");

`else

`define RIQ_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RIQ_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/riq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package riq_pkg;

  localparam int ACTION_W = 3;
  localparam int DATA_W   = 32;
  localparam int STAMP_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_PUSH        = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP         = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK_OLD    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PEEK_NEW    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PEEK_BEFORE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEVER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // decoded result of one item, waiting for its memory read
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic                has_data;
  } result_info_t;

endpackage

`default_nettype wire

// ----- rtl/riq_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface riq_in_if;
  logic                          valid;
  logic                          ready;
  logic [riq_pkg::ACTION_W-1:0]  action;
  logic [riq_pkg::DATA_W-1:0]    entry_data;
  logic [riq_pkg::STAMP_W-1:0]   timestamp;
  logic [riq_pkg::POS_W-1:0]     position_in;

  modport source (output valid, action, entry_data, timestamp, position_in, input ready);
  modport sink (input valid, action, entry_data, timestamp, position_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/riq_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface riq_out_if;
  logic                          valid;
  logic                          ready;
  logic [riq_pkg::STATUS_W-1:0]  status;
  logic [riq_pkg::DATA_W-1:0]    read_payload;
  logic [riq_pkg::STAMP_W-1:0]   read_timestamp;
  logic [riq_pkg::POS_W-1:0]     position;

  modport source (output valid, status, read_payload, read_timestamp, position, input ready);
  modport sink (input valid, status, read_payload, read_timestamp, position, output ready);
endinterface

`default_nettype wire

// ----- rtl/riq_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module riq_store #(
  parameter int DEPTH = 256,
  parameter int SW    = 32
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire logic [SW-1:0]                wdata,
  input  wire logic [riq_pkg::STAMP_W-1:0]  wstamp,
  input  wire logic                         re,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output logic      [SW-1:0]                rdata,
  output logic      [riq_pkg::STAMP_W-1:0]  rstamp
);

  logic [SW-1:0]               payload_mem [DEPTH];
  logic [riq_pkg::STAMP_W-1:0] stamp_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      payload_mem[waddr] <= wdata;
      stamp_mem[waddr]   <= wstamp;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata  <= payload_mem[raddr];
      rstamp <= stamp_mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/riq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "ring_index_queue_assert.svh"

module riq_ctrl #(
  parameter int DEPTH = 256,
  parameter int SW    = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  riq_in_if.sink                            req,
  riq_out_if.source                         rsp,
  output logic                              we,
  output logic [$clog2(DEPTH)-1:0]          waddr,
  output logic [SW-1:0]                     wdata,
  output logic [riq_pkg::STAMP_W-1:0]       wstamp,
  output logic                              re,
  output logic [$clog2(DEPTH)-1:0]          raddr,
  input  wire logic [SW-1:0]                rdata,
  input  wire logic [riq_pkg::STAMP_W-1:0]  rstamp
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic          started, started_next;
  logic          clearing;
  logic [IW-1:0] clr_addr;

  logic                  pend_v;
  riq_pkg::result_info_t pend, pend_next;

  logic                          out_valid;
  riq_pkg::result_info_t         out_info;
  logic [riq_pkg::DATA_W-1:0]    out_data;
  logic [riq_pkg::STAMP_W-1:0]   out_stamp;

  logic          acc;
  logic          advance;
  logic          full;
  logic [IW-1:0] pos_mod;
  logic [IW-1:0] mod_tab [256];

  function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] wrap_prev(input logic [IW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  // position_in reduced modulo the depth, one constant entry per input code
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = IW'(g % DEPTH);
  end
  assign pos_mod = mod_tab[req.position_in];

  assign advance   = pend_v && (!out_valid || rsp.ready);
  assign req.ready = !clearing && (!pend_v || !out_valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign full      = started && (head != tail) && (wrap_next(tail) == head);

  always_comb begin
    we             = 1'b0;
    re             = 1'b0;
    waddr          = tail;
    raddr          = head;
    wdata          = req.entry_data[SW-1:0];
    wstamp         = req.timestamp;
    head_next      = head;
    tail_next      = tail;
    started_next   = started;
    pend_next      = '0;
    pend_next.status = riq_pkg::ST_OK;
    if (clearing) begin
      we     = 1'b1;
      waddr  = clr_addr;
      wdata  = '0;
      wstamp = '0;
    end else if (acc) begin
      unique case (req.action) inside
        riq_pkg::ACT_PUSH: begin
          if (full) begin
            pend_next.status = riq_pkg::ST_FULL;
          end else begin
            we                 = 1'b1;
            pend_next.position = riq_pkg::POS_W'(tail);
            tail_next          = wrap_next(tail);
            started_next       = 1'b1;
          end
        end
        riq_pkg::ACT_POP, riq_pkg::ACT_PEEK_OLD, riq_pkg::ACT_PEEK_NEW,
        riq_pkg::ACT_PEEK_BEFORE: begin
          if (!started) begin
            pend_next.status = riq_pkg::ST_NEVER;
          end else if (head == tail) begin
            pend_next.status = riq_pkg::ST_EMPTY;
          end else begin
            re                 = 1'b1;
            pend_next.has_data = 1'b1;
            unique case (req.action) inside
              riq_pkg::ACT_POP: begin
                head_next = wrap_next(head);
              end
              riq_pkg::ACT_PEEK_OLD: begin
                pend_next.position = riq_pkg::POS_W'(head);
              end
              riq_pkg::ACT_PEEK_NEW: begin
                raddr = wrap_prev(tail);
              end
              default: begin
                raddr = wrap_prev(pos_mod);
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      started  <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      started <= started_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  // pending stage: memory read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (acc) begin
      pend_v <= 1'b1;
    end else if (advance) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend <= pend_next;
    end
  end

  // output register, keeps its own copy of the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_info  <= pend;
      out_data  <= pend.has_data ? riq_pkg::DATA_W'(rdata) : '0;
      out_stamp <= pend.has_data ? rstamp : '0;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_info.status;
  assign rsp.position       = out_info.position;
  assign rsp.read_payload   = out_data;
  assign rsp.read_timestamp = out_stamp;

  `RIQ_ASSERT_NXT(a_started_sticky, clk, rst, started, started)
  `RIQ_ASSERT_IMP(a_idle_indices, clk, rst, !started, (head == '0) && (tail == '0))
  `RIQ_ASSERT_IMP(a_head_range, clk, rst, 1'b1, (head <= LAST) && (tail <= LAST))
  `RIQ_ASSERT_NXT(a_read_pending, clk, rst, re, pend_v && pend.has_data)
  `RIQ_ASSERT_IMP(a_clear_quiet, clk, rst, clearing, !pend_v && !out_valid && !started)

endmodule

`default_nettype wire

// ----- rtl/ring_index_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  payload                                          handshake
// req      in   action, entry_data, timestamp, position_in       valid/ready
// rsp      out  status, read_payload, read_timestamp, position   valid/ready
//
// one result per item; an item can be accepted every cycle unless the store
// is clearing or both pipeline registers are full with the output stalled
// a result passes the pending stage (store read), then the output register
// after reset all DEPTH entries of the store are cleared, one entry per
// cycle, with req.ready low
// a stalled result holds in the output register while one more item is taken

module ring_index_queue #(
  parameter int DEPTH         = 256,
  parameter int PAYLOAD_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  riq_in_if.sink    req,
  riq_out_if.source rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int SW = (PAYLOAD_WIDTH < riq_pkg::DATA_W) ? PAYLOAD_WIDTH : riq_pkg::DATA_W;

  logic                         we;
  logic                         re;
  logic [IW-1:0]                waddr;
  logic [IW-1:0]                raddr;
  logic [SW-1:0]                wdata;
  logic [SW-1:0]                rdata;
  logic [riq_pkg::STAMP_W-1:0]  wstamp;
  logic [riq_pkg::STAMP_W-1:0]  rstamp;

  riq_ctrl #(
    .DEPTH (DEPTH),
    .SW    (SW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .wstamp (wstamp),
    .re     (re),
    .raddr  (raddr),
    .rdata  (rdata),
    .rstamp (rstamp)
  );

  riq_store #(
    .DEPTH (DEPTH),
    .SW    (SW)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .wstamp (wstamp),
    .re     (re),
    .raddr  (raddr),
    .rdata  (rdata),
    .rstamp (rstamp)
  );

endmodule

`default_nettype wire
